// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module ap_checker.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");

`endif

// ===== sv/ap_pkg.sv =====
// Types and constants for the Ascon permutation block.
// No dependencies; imported by every module of the block.
package ap_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned ROUND_W = 4;
	localparam logic [ROUND_W-1:0] FULL_ROUNDS = 4'd12;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ROUND_W-1:0] round_t;
	typedef word_t [4:0] state_t;

	typedef struct packed {
		word_t  word0;
		word_t  word1;
		word_t  word2;
		word_t  word3;
		word_t  word4;
		round_t round_count;
	} in_t;

	typedef struct packed {
		word_t out_word0;
		word_t out_word1;
		word_t out_word2;
		word_t out_word3;
		word_t out_word4;
	} out_t;

endpackage

// ===== sv/ap_round.sv =====
// One Ascon round: constant addition, 5-bit substitution, linear diffusion.
// Depends on ap_pkg; used by ascon_permutation once per cycle while a run is active.
module ap_round (
	input  ap_pkg::state_t cur,
	input  ap_pkg::round_t rnd,
	output ap_pkg::state_t nxt
);
	import ap_pkg::*;

	function automatic word_t rotr(input word_t v, input int unsigned s);
		logic [2*WORD_W-1:0] dbl;
		dbl  = {v, v} >> s;
		rotr = dbl[WORD_W-1:0];
	endfunction

	word_t  a0, a1, a2, a3, a4;
	word_t  b0, b1, b2, b3, b4;
	word_t  c0, c1, c2, c3, c4;
	logic [7:0] rc;

	always_comb begin
		rc = {FULL_ROUNDS + 4'd3 - rnd, rnd};

		a0 = cur[0] ^ cur[4];
		a4 = cur[4] ^ cur[3];
		a2 = cur[2] ^ {56'd0, rc} ^ cur[1];
		a1 = cur[1];
		a3 = cur[3];

		// chi-like layer, bitsliced over the five words
		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);

		c1 = b1 ^ b0;
		c0 = b0 ^ b4;
		c3 = b3 ^ b2;
		c2 = ~b2;
		c4 = b4;

		nxt[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
		nxt[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
		nxt[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
		nxt[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
		nxt[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);
	end

endmodule

// ===== sv/ascon_permutation.sv =====
// Ascon 320-bit permutation, one round per clock through a shared round unit.
// Depends on ap_pkg and ap_round.
//
// Usage:
//   Drive item (five state words and round_count) and raise start while busy
//   is low; the transfer happens at that rising edge. round_count above
//   MAX_ROUNDS is clamped to MAX_ROUNDS; the n rounds use indices 12-n..11.
//   The result appears on result, with done high for exactly one cycle.
// Sequencing:
//   Each round passes the state through the round unit into the state
//   register; done rises as busy falls after the last round (in the cycle
//   right after the transfer for n = 0, which returns the words unchanged).
//   busy is high while rounds run, and a new start is taken in the done cycle,
//   so no new item is taken while the single round unit works on the last one.
// Reset:
//   arst_n low clears the sequencer and drops busy and done at once.
// Output side:
//   The receiver cannot stall; a result must be captured while done is high.
module ascon_permutation #(
	parameter int MAX_ROUNDS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  ap_pkg::in_t  item,
	output logic         done,
	output ap_pkg::out_t result
);
	import ap_pkg::*;

	localparam round_t MaxRounds = ROUND_W'(MAX_ROUNDS);
	localparam round_t LastRound = FULL_ROUNDS - 4'd1;

	typedef enum logic {
		IDLE,
		RUN
	} fsm_t;

	fsm_t   fsm_q;
	state_t st_q;
	round_t rnd_q;
	logic   done_q;
	out_t   result_q;
	state_t st_nxt;
	round_t n_sat;

	assign n_sat = (item.round_count > MaxRounds) ? MaxRounds : item.round_count;

	ap_round u_round (
		.cur (st_q),
		.rnd (rnd_q),
		.nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= IDLE;
			done_q   <= 1'b0;
			rnd_q    <= '0;
			st_q     <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (fsm_q)
				IDLE: begin
					if (start) begin
						if (n_sat == '0) begin
							result_q <= '{item.word0, item.word1, item.word2,
							              item.word3, item.word4};
							done_q   <= 1'b1;
						end else begin
							st_q  <= '{item.word4, item.word3, item.word2,
							           item.word1, item.word0};
							rnd_q <= FULL_ROUNDS - n_sat;
							fsm_q <= RUN;
						end
					end
				end
				RUN: begin
					st_q  <= st_nxt;
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == LastRound) begin
						result_q <= '{st_nxt[0], st_nxt[1], st_nxt[2],
						              st_nxt[3], st_nxt[4]};
						done_q   <= 1'b1;
						fsm_q    <= IDLE;
					end
				end
				default: fsm_q <= IDLE;
			endcase
		end
	end

	assign busy   = (fsm_q == RUN);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/ap_checker.sv =====
// Port-level timing checks for ascon_permutation, attached by bind.
// Depends on ap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input ap_pkg::in_t item
);
	import ap_pkg::*;

	// zero rounds: result next cycle, block stays free
	`AP_ASSERT_NEXT(a_zero_rounds, clk, arst_n, start && !busy && item.round_count == 4'd0, done && !busy)
	// any rounds: block goes busy after the transfer
	`AP_ASSERT_NEXT(a_go_busy, clk, arst_n, start && !busy && item.round_count != 4'd0, busy && !done)
	// end of a run always delivers a result
	`AP_ASSERT_IMPL(a_end_done, clk, arst_n, $fell(busy), done)
	// no result while rounds are still running
	`AP_ASSERT_IMPL(a_no_early, clk, arst_n, busy, !done)

endmodule

bind ascon_permutation ap_checker u_ap_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.item   (item)
);

// ===== verif/ascon_permutation_tb.sv =====
// Self-checking testbench for ascon_permutation: directed and random states over all round counts.
// Depends on ap_pkg and the ascon_permutation RTL; holds its own bit-exact permutation predictor.
module ascon_permutation_tb;
	import ap_pkg::*;

	localparam int MAX_ROUNDS  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int TAIL_CYCLES = 30;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	in_t  item;
	out_t result;

	in_t  pending_items[$];
	out_t expected_states[$];

	int   error_count;
	int   sent_count;
	int   checked_count;
	int   cycle_count;
	bit   rounds_seen[16];

	// driver pacing
	int   gap_left;
	bit   rested;
	int   idle_pct;

	ascon_permutation #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #4 clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic word_t ror64(input word_t v, input int s);
		return (v >> s) | (v << (64 - s));
	endfunction

	// n rounds use round indices 12-n .. 11; counts above MAX_ROUNDS saturate
	function automatic out_t permute_state(input in_t it);
		word_t w[5];
		word_t a0, a1, a2, a3, a4;
		word_t n0, n1, n2, n3, n4;
		int    n;
		out_t  o;
		w[0] = it.word0;
		w[1] = it.word1;
		w[2] = it.word2;
		w[3] = it.word3;
		w[4] = it.word4;
		n = int'(it.round_count);
		if (n > MAX_ROUNDS)
			n = MAX_ROUNDS;
		for (int r = int'(FULL_ROUNDS) - n; r < int'(FULL_ROUNDS); r++) begin
			w[2] ^= word_t'(((15 - r) << 4) | r);
			a0 = w[0] ^ w[4];
			a4 = w[4] ^ w[3];
			a2 = w[2] ^ w[1];
			a1 = w[1];
			a3 = w[3];
			n0 = ~a0 & a1;
			n1 = ~a1 & a2;
			n2 = ~a2 & a3;
			n3 = ~a3 & a4;
			n4 = ~a4 & a0;
			a0 ^= n1;
			a1 ^= n2;
			a2 ^= n3;
			a3 ^= n4;
			a4 ^= n0;
			a1 ^= a0;
			a0 ^= a4;
			a3 ^= a2;
			a2 = ~a2;
			w[0] = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
			w[1] = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
			w[2] = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
			w[3] = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
			w[4] = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
		end
		o.out_word0 = w[0];
		o.out_word1 = w[1];
		o.out_word2 = w[2];
		o.out_word3 = w[3];
		o.out_word4 = w[4];
		return o;
	endfunction

	function automatic in_t make_item(input word_t w0, input word_t w1, input word_t w2,
		input word_t w3, input word_t w4, input round_t n);
		in_t it;
		it.word0 = w0;
		it.word1 = w1;
		it.word2 = w2;
		it.word3 = w3;
		it.word4 = w4;
		it.round_count = n;
		return it;
	endfunction

	// mostly dense random words, with some sparse and saturated ones
	function automatic word_t rand_word();
		int    sel;
		word_t v;
		sel = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (sel == 0)
			v = word_t'(1) << $urandom_range(0, 63);
		else if (sel == 1)
			v = ~(word_t'(1) << $urandom_range(0, 63));
		else if (sel == 2)
			v = $urandom_range(0, 1) ? '1 : '0;
		return v;
	endfunction

	function automatic round_t rand_rounds();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return round_t'(0);
		else if (sel == 1)
			return round_t'($urandom_range(13, 15));
		else if (sel < 8)
			return FULL_ROUNDS;
		return round_t'($urandom_range(1, 12));
	endfunction

	// driver: a transfer happens at an edge where start is high and busy is low
	always @(posedge clk) begin
		bit took;
		took = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				took = 1'b1;
				expected_states.push_back(permute_state(item));
				rounds_seen[item.round_count] = 1'b1;
				void'(pending_items.pop_front());
				sent_count++;
				if (sent_count % 64 == 0)
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 25;
						default: idle_pct = 60;
					endcase
			end
			if (start && !took) begin
				// hold the request until the block takes it
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (!rested && pending_items.size() > 150
				&& $urandom_range(0, 99) < idle_pct) begin
				gap_left <= $urandom_range(1, 3) - 1;
				rested <= 1'b1;
				start <= 1'b0;
			end else begin
				rested <= 1'b0;
				start <= 1'b1;
				item <= pending_items[0];
			end
		end
	end

	// monitor: each done cycle carries one result
	always @(posedge clk) begin
		state_t got_w;
		state_t want_w;
		out_t   want;
		if (arst_n && done) begin
			if (expected_states.size() == 0) begin
				report_error("result with no pending expectation");
			end else begin
				want = expected_states.pop_front();
				got_w = state_t'(result);
				want_w = state_t'(want);
				for (int k = 0; k < 5; k++)
					if (got_w[4-k] !== want_w[4-k])
						report_error($sformatf("result %0d word%0d: got %016h, want %016h",
							checked_count, k, got_w[4-k], want_w[4-k]));
				checked_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: cycle limit reached with %0d items and %0d results outstanding",
				pending_items.size(), expected_states.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int covered;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		error_count = 0;
		sent_count = 0;
		checked_count = 0;
		cycle_count = 0;
		gap_left = 0;
		rested = 1'b0;
		idle_pct = 25;

		// zero state through every round count, including zero and saturating ones; then all-ones and alternating-bit states
		for (int n = 0; n < 16; n++)
			pending_items.push_back(make_item('0, '0, '0, '0, '0, round_t'(n)));
		pending_items.push_back(make_item('1, '1, '1, '1, '1, FULL_ROUNDS));
		pending_items.push_back(make_item('1, '1, '1, '1, '1, round_t'(6)));
		pending_items.push_back(make_item('1, '1, '1, '1, '1, round_t'(8)));
		pending_items.push_back(make_item('1, '1, '1, '1, '1, round_t'(1)));
		pending_items.push_back(make_item('1, '1, '1, '1, '1, round_t'(0)));
		pending_items.push_back(make_item({32{2'b10}}, {32{2'b01}}, {32{2'b10}},
			{32{2'b01}}, {32{2'b10}}, FULL_ROUNDS));
		pending_items.push_back(make_item({32{2'b01}}, {32{2'b10}}, {32{2'b01}},
			{32{2'b10}}, {32{2'b01}}, round_t'(15)));
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_items.push_back(make_item(rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_rounds()));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || expected_states.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_states.size() != 0)
			report_error($sformatf("%0d expected results never arrived",
				expected_states.size()));

		covered = 0;
		for (int n = 0; n < 16; n++)
			covered += rounds_seen[n];
		$display("Ran %0d permutations (%0d of 16 round counts) and checked %0d results.",
			sent_count, covered, checked_count);
		$display("Mismatches and protocol errors: %0d", error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/ap_pkg.sv
sv/ap_round.sv
sv/ascon_permutation.sv
sv/ap_checker.sv
verif/ascon_permutation_tb.sv
